>>> rtl/maf_pkg.sv
// shared types and constants of the moving average filter
package maf_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 16;
  localparam int TAG_W      = 32;
  localparam int LEN_W      = 7;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  // running sum keeps headroom for offsets left by window changes
  localparam int SUM_W      = 40;
  localparam int REM_W      = LEN_W + 1;
  // two quotient bits per cycle
  localparam int DIV_STEPS  = SUM_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(20);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TAG_W-1:0]           time_tag;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean;
    logic [TAG_W-1:0]           time_tag_out;
  } out_item_t;

endpackage

>>> rtl/moving_average_filter.sv
// moving average filter top level: history memory, running sum, divider
//
// usage
//   input channel in_valid / in_stall / in_data carries one sample and its
//   time tag per item; an item is taken when in_valid is high and in_stall
//   low. the output channel out_valid / out_stall / out_data returns the mean
//   of the newest window_len samples with the same time tag.
//   cfg_valid / cfg_ready / cfg_data writes window_len (0 acts as 1, values
//   above 64 act as 64); write it only while the block is idle, then reset.
// sequence
//   one item at a time: memory read, then sum update and history write,
//   then division (two quotient bits a cycle over the 40-bit sum), then
//   loading of the output register.
//   the output register lets the next item enter while a result waits.
// reset
//   rst (synchronous) clears window_len to 20, the sum, the write pointer and
//   the per-entry valid bits, so all history reads as zero; no clearing pass.
// stall
//   a stalled result holds in the output register; a finished division then
//   waits until the register frees up, and no new item is taken meanwhile.
module moving_average_filter
  import maf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [LEN_W-1:0] window_len;
  logic [LEN_W-1:0] eff_len;

  // history memory with per-entry valid bits
  logic [SAMPLE_W-1:0]   hist_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] hist_vld;
  logic [SAMPLE_W-1:0]   rd_data;
  logic                  rd_ok;

  logic [PTR_W-1:0] write_pos;
  logic [PTR_W-1:0] old_pos;

  logic signed [SUM_W-1:0] window_sum;
  logic signed [SUM_W-1:0] window_sum_next;
  logic signed [SUM_W-1:0] smp_ext;
  logic signed [SUM_W-1:0] leave_ext;
  logic [SUM_W-1:0]        sum_mag;

  // item being worked on
  logic signed [SAMPLE_W-1:0] smp;
  logic [TAG_W-1:0]           tag;
  logic [LEN_W-1:0]           len;

  // divider state
  logic [SUM_W-1:0] dq;
  logic [SUM_W-1:0] dq_next;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem_next;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic signed [SAMPLE_W-1:0] mean_sat;

  logic in_acc;
  logic out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // clamp the register to 1..WINDOW_MAX
  always_comb begin
    if (window_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (window_len > LEN_W'(WINDOW_MAX)) begin
      eff_len = LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = window_len;
    end
  end

  // slot of the sample leaving the window (pos - len, modulo the depth)
  assign old_pos = write_pos - eff_len[PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_len <= cfg_data;
    end
  end

  // memory read of the leaving sample, issued on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data <= hist_mem[old_pos];
    end
  end

  // memory write of the new sample during the sum update
  always_ff @(posedge clk) begin
    if (state == S_ACC) begin
      hist_mem[write_pos] <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
    end else if (state == S_ACC) begin
      hist_vld[write_pos] <= 1'b1;
    end
  end

  // running sum update, never-written entries count as zero
  always_comb begin
    smp_ext         = SUM_W'(smp);
    leave_ext       = rd_ok ? SUM_W'($signed(rd_data)) : '0;
    window_sum_next = window_sum + smp_ext - leave_ext;
    sum_mag         = window_sum_next[SUM_W-1] ? SUM_W'(-window_sum_next)
                                               : SUM_W'(window_sum_next);
  end

  // two restoring division steps per cycle
  always_comb begin
    logic [REM_W-1:0] r_sh;
    logic [SUM_W-1:0] d;
    logic [REM_W-1:0] r;
    d = dq;
    r = rem;
    for (int k = 0; k < 2; k++) begin
      r_sh = {r[REM_W-2:0], d[SUM_W-1]};
      d    = {d[SUM_W-2:0], 1'b0};
      if (r_sh >= REM_W'(len)) begin
        r    = r_sh - REM_W'(len);
        d[0] = 1'b1;
      end else begin
        r = r_sh;
      end
    end
    dq_next  = d;
    rem_next = r;
  end

  // sign and saturation of the quotient
  always_comb begin
    if (neg) begin
      if (dq > SUM_W'(32'd1 << (SAMPLE_W - 1))) begin
        mean_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        mean_sat = -$signed(dq[SAMPLE_W-1:0]);
      end
    end else begin
      if (dq > SUM_W'((32'd1 << (SAMPLE_W - 1)) - 32'd1)) begin
        mean_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
        mean_sat = $signed(dq[SAMPLE_W-1:0]);
      end
    end
  end

  // sequencer with state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      window_sum <= '0;
      write_pos  <= '0;
      rd_ok      <= 1'b0;
      cnt        <= '0;
    end else begin
      // a taken result frees the register unless a new one loads this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            smp   <= in_data.sample;
            tag   <= in_data.time_tag;
            len   <= eff_len;
            rd_ok <= hist_vld[old_pos];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          window_sum <= window_sum_next;
          write_pos  <= write_pos + PTR_W'(1);
          dq         <= sum_mag;
          neg        <= window_sum_next[SUM_W-1];
          rem        <= '0;
          cnt        <= '0;
          state      <= S_DIV;
        end
        S_DIV: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data.mean         <= mean_sat;
            out_data.time_tag_out <= tag;
            out_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an accepted item blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not blocked after accepting an item");

  // each sum update advances the write pointer by exactly one slot
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |=> write_pos == $past(write_pos) + PTR_W'(1))
    else $error("write pointer did not advance by one");

  // the divider count never runs past its last step
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= CNT_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");

  // a finished result waits while the output register is held
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && out_stall |=> state == S_DONE)
    else $error("result lost while output stalled");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the moving average filter: predictor, scoreboard, stimulus
import maf_pkg::*;

// kinds of sample content a phase is filled with
typedef enum int {FILL_FULL, FILL_SMALL, FILL_EXTREME, FILL_LEVEL} fill_t;

// running-mean predictor plus the queue of means still owed by the block
class mean_scoreboard;
  logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
  longint                     window_sum;
  logic [PTR_W-1:0]           write_pos;
  logic [LEN_W-1:0]           window_len;
  out_item_t                  mean_q [$];
  int                         errors;
  int                         checked;
  int                         saturated;
  int                         len_writes;

  function new();
    foreach (history[i]) history[i] = '0;
    window_sum = 0;
    write_pos  = '0;
    window_len = LEN_RESET;
  endfunction

  // 0 acts as 1, anything above the store depth acts as the full depth
  function int clip_len(logic [LEN_W-1:0] raw);
    int len;
    len = raw;
    if (len < 1) len = 1;
    if (len > WINDOW_MAX) len = WINDOW_MAX;
    return len;
  endfunction

  function void set_len(logic [LEN_W-1:0] raw);
    window_len = raw;
    len_writes++;
  endfunction

  // part of the sum that is not explained by the newest window_len samples
  function longint window_offset();
    longint           held;
    logic [PTR_W-1:0] p;
    int               len;
    held = 0;
    p    = write_pos;
    len  = clip_len(window_len);
    for (int k = 0; k < len; k++) begin
      p = p - 1'b1;
      held += history[p];
    end
    return window_sum - held;
  endfunction

  function void note_sample(in_item_t item);
    int               len;
    logic [PTR_W-1:0] old_pos;
    longint           quot;
    out_item_t        want;
    len     = clip_len(window_len);
    // full depth wraps the pointer back onto the slot being overwritten
    old_pos = write_pos - PTR_W'(len);
    window_sum = window_sum + longint'($signed(item.sample)) - longint'(history[old_pos]);
    history[write_pos] = item.sample;
    write_pos = write_pos + 1'b1;
    quot = window_sum / len;
    if (quot > 32767) begin
      quot = 32767;
      saturated++;
    end else if (quot < -32768) begin
      quot = -32768;
      saturated++;
    end
    want.mean         = quot[SAMPLE_W-1:0];
    want.time_tag_out = item.time_tag;
    mean_q.insert(mean_q.size(), want);
  endfunction

  function void flag(string what, longint want_v, longint got_v);
    errors++;
    if (errors <= 10)
      $display("mismatch %0d, %s: expected %0d, got %0d", errors, what, want_v, got_v);
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (mean_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %0d, item with nothing pending: mean %0d tag %h",
                 errors, $signed(got.mean), got.time_tag_out);
      return;
    end
    want = mean_q.pop_front();
    checked++;
    if (got.mean !== want.mean)
      flag("mean", $signed(want.mean), $signed(got.mean));
    if (got.time_tag_out !== want.time_tag_out)
      flag("time tag", want.time_tag_out, got.time_tag_out);
  endfunction

  function int pending();
    return mean_q.size();
  endfunction
endclass

module testbench;

  localparam int STUCK_LIMIT  = 2000;
  localparam int ITEM_TARGET  = 1350;
  localparam int SETTLE_CYCLES = 60;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data  = '0;

  mean_scoreboard sb = new();
  bit             quiet = 1'b0;   // phase with no idling on either side
  int             items_sent = 0;
  int             stuck_cycles = 0;

  moving_average_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // per-item wait, none at all in quiet phases
  function automatic int idle_draw();
    if (quiet) return 0;
    return $urandom_range(0, 5);
  endfunction

  function automatic int clamp_sample(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // offer one item, hold it until taken, then log it with the predictor
  task automatic send_item(input int value, input logic [TAG_W-1:0] tag);
    in_item_t item;
    int       gap;
    item.sample   = value[SAMPLE_W-1:0];
    item.time_tag = tag;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sb.note_sample(item);
    items_sent++;
  endtask

  // drop valid and wait until every owed mean has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_len(value);
    cfg_valid <= 1'b0;
  endtask

  // next window length, extremes and out-of-range codes favored
  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return LEN_W'(0);
      1:       return LEN_W'(1);
      2:       return LEN_W'(WINDOW_MAX);
      3:       return LEN_W'(127);
      4:       return LEN_W'($urandom_range(WINDOW_MAX + 1, 126));
      5:       return LEN_RESET;
      default: return LEN_W'($urandom_range(2, WINDOW_MAX - 1));
    endcase
  endfunction

  // one run of samples under the current length; the tail is usually shaped
  // so that switching to next_len cancels the sum offset built up so far,
  // otherwise the offset grows and the means tend to saturate
  task automatic run_phase(input logic [LEN_W-1:0] next_len);
    int     samples [$];
    int     cur_eff, nxt_eff, n, level, lo, hi, v;
    fill_t  fill;
    longint target;
    cur_eff = sb.clip_len(sb.window_len);
    nxt_eff = sb.clip_len(next_len);
    lo      = (cur_eff < nxt_eff) ? cur_eff : nxt_eff;
    hi      = (cur_eff > nxt_eff) ? cur_eff : nxt_eff;
    n       = hi + $urandom_range(0, 40);
    fill    = fill_t'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) fill = FILL_FULL;
    level   = int'($urandom_range(0, 65535)) - 32768;
    quiet   = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_FULL:    samples.insert(i, int'($urandom_range(0, 65535)) - 32768);
        FILL_SMALL:   samples.insert(i, int'($urandom_range(0, 200)) - 100);
        FILL_EXTREME: samples.insert(i, $urandom_range(0, 1) ? 32767 : -32768);
        default:      samples.insert(i, level);
      endcase
    end
    if (cur_eff != nxt_eff && $urandom_range(0, 3) != 0) begin
      // samples whose age lies between the two lengths decide the new offset
      target = (nxt_eff < cur_eff) ? -sb.window_offset() : sb.window_offset();
      for (int age = lo; age < hi; age++) begin
        v = clamp_sample(target / (hi - age));
        samples[n - 1 - age] = v;
        target -= v;
      end
    end
    foreach (samples[i]) send_item(samples[i], $urandom());
  endtask

  // receiver: stalls land on waiting results for a drawn number of cycles
  initial begin
    int hold;
    wait (rst === 1'b0);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // every mean taken from the block is checked against the oldest owed one
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  // watchdog: nothing moving on any channel for too long means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("no handshake for %0d cycles", STUCK_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [LEN_W-1:0] next_len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset length: field extremes and tag bit patterns
    send_item(32767, 32'h0000_0000);
    send_item(-32768, 32'hFFFF_FFFF);
    send_item(0, 32'h5555_5555);
    send_item(-1, 32'hAAAA_AAAA);
    send_item(1, 32'h8000_0001);
    send_item(32767, 32'h7FFF_FFFE);
    drain();

    // zero length acts as one; the small offset pushes the first mean below range
    write_len(LEN_W'(0));
    send_item(-32768, 32'h0000_0001);
    send_item(32767, 32'hFFFF_FFFE);
    send_item(-1, 32'h1234_5678);
    drain();

    // fill a short window with the top value
    write_len(LEN_W'(4));
    repeat (4) send_item(32767, $urandom());
    drain();

    // shrinking without a reset leaves a large offset: the first mean clips high
    write_len(LEN_W'(1));
    send_item(32767, $urandom());
    send_item(-32768, $urandom());
    drain();

    // top code acts as the full store depth
    write_len(LEN_W'(127));
    send_item(-32768, $urandom());
    send_item(12345, $urandom());
    send_item(-1, $urandom());
    drain();

    // random phases, each but the last ended by a length change while idle
    forever begin
      next_len = pick_len();
      run_phase(next_len);
      if (items_sent >= ITEM_TARGET) break;
      drain();
      write_len(next_len);
    end
    drain();
    quiet = 1'b0;
    // catch any stray result after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d samples sent, %0d means checked over %0d window length writes",
             items_sent, sb.checked, sb.len_writes);
    $display("%0d means were clipped to the sample range", sb.saturated);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d means still owed", sb.errors, sb.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
